>>> rtl/assert_macros.svh
// assertion macros for the job scheduler rtl
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/tdjs_pkg.sv
// shared types and constants for the job scheduler
// no dependencies
package tdjs_pkg;
    localparam int QueueDepth = 16;

    localparam logic [1:0] ModeFcfs = 2'd0;
    localparam logic [1:0] ModeSrtf = 2'd1;
    localparam logic [1:0] ModePrio = 2'd2;

    localparam logic [1:0] StDone     = 2'd0;
    localparam logic [1:0] StFull     = 2'd1;
    localparam logic [1:0] StZeroBurst = 2'd2;

    localparam logic OpAdmit = 1'b0;
    localparam logic OpTick  = 1'b1;

    // classified command between front and back
    typedef struct packed {
        logic        reject;
        logic [1:0]  status;
        logic        tick;
        logic [7:0]  job_id;
        logic [15:0] burst;
        logic [7:0]  job_priority;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  done_id;
        logic [31:0] completion_time;
        logic [31:0] turnaround;
        logic [31:0] waiting;
    } t_res;
endpackage

>>> rtl/tdjs_front.sv
// front end: accepts items, classifies admits against zero burst
// depends on tdjs_pkg
module tdjs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_operation,
    input  logic [7:0]       i_job_id,
    input  logic [15:0]      i_burst,
    input  logic [7:0]       i_job_priority,
    output logic             o_cmd_valid,
    output tdjs_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_ready
);
    // two-entry queue
    tdjs_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt, n_cnt;
    tdjs_pkg::t_cmd w_c;
    logic           w_push, w_pop;

    always_comb begin
        w_c.tick         = (i_operation == tdjs_pkg::OpTick);
        w_c.reject       = (i_operation == tdjs_pkg::OpAdmit) && (i_burst == 16'd0);
        w_c.status       = tdjs_pkg::StZeroBurst;
        w_c.job_id       = i_job_id;
        w_c.burst        = i_burst;
        w_c.job_priority = i_job_priority;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];
    assign n_cnt       = r_cnt + {1'b0, w_push} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_c;
    end
endmodule

>>> rtl/tdjs_back.sv
// back end: job table, sequential pick scan, compaction, result register
// depends on tdjs_pkg
module tdjs_back #(
    parameter int QUEUE_DEPTH = tdjs_pkg::QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_mode,
    input  logic             i_cmd_valid,
    input  tdjs_pkg::t_cmd   i_cmd,
    output logic             o_cmd_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output tdjs_pkg::t_res   o_res,
    output logic             o_busy
);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

    localparam logic [2:0] SIdle  = 3'd0;
    localparam logic [2:0] SScan  = 3'd1;
    localparam logic [2:0] SDec   = 3'd2;
    localparam logic [2:0] SShift = 3'd3;
    localparam logic [2:0] SOut   = 3'd4;

    logic [7:0]  r_id   [QUEUE_DEPTH];
    logic [15:0] r_rem  [QUEUE_DEPTH];
    logic [15:0] r_bst  [QUEUE_DEPTH];
    logic [31:0] r_arr  [QUEUE_DEPTH];
    logic [7:0]  r_pri  [QUEUE_DEPTH];

    logic [2:0]    r_st;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_time;
    logic [CW-1:0] r_i;
    logic [IW-1:0] r_best;
    logic [15:0]   r_key;
    logic          r_ov;
    tdjs_pkg::t_res r_res, n_res;

    logic [IW-1:0] w_i;
    logic [15:0]   w_key;
    logic          w_take;
    logic [31:0]   w_ct, w_tat;

    assign w_i = r_i[IW-1:0];
    assign w_key = (i_mode == tdjs_pkg::ModeSrtf) ? r_rem[w_i]
                 : {8'd0, r_pri[w_i]};
    assign w_take = ((i_mode == tdjs_pkg::ModeSrtf) || (i_mode == tdjs_pkg::ModePrio))
                    && (w_key < r_key);
    assign w_ct  = r_time + 32'd1;
    assign w_tat = w_ct - r_arr[r_best];

    assign o_cmd_ready = (r_st == SIdle) && !r_ov;
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign o_busy  = (r_st != SIdle) || r_ov;

    always_comb begin
        n_res.status          = tdjs_pkg::StDone;
        n_res.done_id         = r_id[r_best];
        n_res.completion_time = w_ct;
        n_res.turnaround      = w_tat;
        n_res.waiting         = w_tat - {16'd0, r_bst[r_best]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= SIdle;
            r_cnt  <= '0;
            r_time <= '0;
            r_ov   <= 1'b0;
            r_i    <= '0;
            r_best <= '0;
            r_key  <= '0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                SIdle: begin
                    if (i_cmd_valid && !r_ov) begin
                        if (!i_cmd.tick) begin
                            if (i_cmd.reject || r_cnt >= DepthC) begin
                                r_ov <= 1'b1;
                                r_res.status <= i_cmd.reject ? i_cmd.status
                                                             : tdjs_pkg::StFull;
                                r_res.done_id <= i_cmd.job_id;
                                r_res.completion_time <= '0;
                                r_res.turnaround <= '0;
                                r_res.waiting <= '0;
                            end else begin
                                r_id[r_cnt[IW-1:0]]  <= i_cmd.job_id;
                                r_rem[r_cnt[IW-1:0]] <= i_cmd.burst;
                                r_bst[r_cnt[IW-1:0]] <= i_cmd.burst;
                                r_arr[r_cnt[IW-1:0]] <= r_time;
                                r_pri[r_cnt[IW-1:0]] <= i_cmd.job_priority;
                                r_cnt <= r_cnt + CW'(1);
                            end
                        end else if (r_cnt == '0) begin
                            r_time <= r_time + 32'd1;
                        end else begin
                            r_i    <= '0;
                            r_best <= '0;
                            r_key  <= 16'hffff;
                            r_st   <= SScan;
                        end
                    end
                end
                SScan: begin
                    // one entry per cycle, strict less keeps the earliest
                    if (r_i == '0 || w_take) begin
                        r_best <= w_i;
                        r_key  <= w_key;
                    end
                    if (r_i + CW'(1) >= r_cnt) r_st <= SDec;
                    r_i <= r_i + CW'(1);
                end
                SDec: begin
                    r_rem[r_best] <= r_rem[r_best] - 16'd1;
                    if (r_rem[r_best] == 16'd1) begin
                        r_res <= n_res;
                        r_i   <= CW'(r_best);
                        r_st  <= SOut;
                    end else begin
                        r_time <= w_ct;
                        r_st   <= SIdle;
                    end
                end
                SOut: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_st <= SShift;
                    end
                end
                SShift: begin
                    // compact the table one entry per cycle
                    if (r_i + CW'(1) < r_cnt) begin
                        r_id[w_i]  <= r_id[w_i + IW'(1)];
                        r_rem[w_i] <= r_rem[w_i + IW'(1)];
                        r_bst[w_i] <= r_bst[w_i + IW'(1)];
                        r_arr[w_i] <= r_arr[w_i + IW'(1)];
                        r_pri[w_i] <= r_pri[w_i + IW'(1)];
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_cnt  <= r_cnt - CW'(1);
                        r_time <= w_ct;
                        r_st   <= SIdle;
                    end
                end
                default: r_st <= SIdle;
            endcase
        end
    end
endmodule

>>> rtl/tick_driven_job_scheduler.sv
// top level of the tick driven job scheduler: mode register, front, back
// depends on tdjs_pkg, tdjs_front, tdjs_back, assert_macros.svh
//
// channel  | handshake            | payload
// input    | i_valid / o_ready    | i_operation i_job_id i_burst i_job_priority
// output   | o_valid / i_ready    | o_status o_done_id o_completion_time o_turnaround o_waiting
// config   | i_cfg_we             | i_cfg_data (mode)
//
// an admit is stored straight from the idle state; a tick scans the n stored jobs,
// decrements the chosen one and, when a job finishes, outputs its result and compacts the table
// the back end works one transaction at a time; a two-entry queue buffers the front
// the output register holds a result until taken, stalling the back end only then
// synchronous active-low reset empties the table and clears the time
`include "assert_macros.svh"
module tick_driven_job_scheduler #(
    parameter int QUEUE_DEPTH = tdjs_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_job_id,
    input  logic [15:0] i_burst,
    input  logic [7:0]  i_job_priority,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_done_id,
    output logic [31:0] o_completion_time,
    output logic [31:0] o_turnaround,
    output logic [31:0] o_waiting
);
    logic [1:0]     r_mode;
    logic           w_cmd_valid, w_cmd_ready, w_busy;
    tdjs_pkg::t_cmd w_cmd;
    tdjs_pkg::t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= tdjs_pkg::ModeFcfs;
        else if (i_cfg_we) r_mode <= i_cfg_data;
    end

    tdjs_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_operation, .i_job_id, .i_burst,
        .i_job_priority, .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd),
        .i_cmd_ready(w_cmd_ready)
    );

    tdjs_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_mode(r_mode), .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_ready(w_cmd_ready), .o_valid, .i_ready, .o_res(w_res), .o_busy(w_busy)
    );

    assign o_status          = w_res.status;
    assign o_done_id         = w_res.done_id;
    assign o_completion_time = w_res.completion_time;
    assign o_turnaround      = w_res.turnaround;
    assign o_waiting         = w_res.waiting;

    `CHK_IMPL(a_valid_busy, i_clk, i_rst_n, o_valid, w_busy)
    `CHK_IMPL(a_done_times, i_clk, i_rst_n, o_valid && o_status == tdjs_pkg::StDone,
        o_turnaround - o_waiting != 32'd0)
    `CHK_NEXT(a_no_take_busy, i_clk, i_rst_n, w_cmd_valid && w_cmd_ready, w_busy || !o_valid)
endmodule

>>> tb/tick_driven_job_scheduler_tb.sv
// testbench for tick_driven_job_scheduler: directed and random admit/tick traffic
// self-checking against an in-bench scheduler prediction; depends on tdjs_pkg and the rtl
module tick_driven_job_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 2000000;
    localparam int SettleCycles = 200;
    // the spare mode code, served first come first served
    localparam logic [1:0] ModeSpare = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_operation = 1'b0;
    logic [7:0]  i_job_id = '0;
    logic [15:0] i_burst = '0;
    logic [7:0]  i_job_priority = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_done_id;
    logic [31:0] o_completion_time;
    logic [31:0] o_turnaround;
    logic [31:0] o_waiting;

    tick_driven_job_scheduler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_job_id(i_job_id),
        .i_burst(i_burst), .i_job_priority(i_job_priority),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_done_id(o_done_id),
        .o_completion_time(o_completion_time),
        .o_turnaround(o_turnaround), .o_waiting(o_waiting)
    );

    always #5 i_clk = ~i_clk;

    // scheduler state mirror
    logic [1:0]  sched_mode;
    logic [31:0] sched_time;
    int          job_count;
    logic [7:0]  job_id_tbl[tdjs_pkg::QueueDepth];
    logic [15:0] job_left_tbl[tdjs_pkg::QueueDepth];
    logic [15:0] job_burst_tbl[tdjs_pkg::QueueDepth];
    logic [31:0] job_arrival_tbl[tdjs_pkg::QueueDepth];
    logic [7:0]  job_prio_tbl[tdjs_pkg::QueueDepth];

    tdjs_pkg::t_res pending_results[$];
    int   error_count = 0;
    int   cycle_count = 0;
    int   ready_gap = 0;
    bit   calm = 1'b0;

    function automatic void expect_result(tdjs_pkg::t_res r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic int choose_job();
        int best;
        best = 0;
        for (int i = 1; i < job_count; i++) begin
            if (sched_mode == tdjs_pkg::ModeSrtf && job_left_tbl[i] < job_left_tbl[best])
                best = i;
            else if (sched_mode == tdjs_pkg::ModePrio && job_prio_tbl[i] < job_prio_tbl[best])
                best = i;
        end
        return best;
    endfunction

    function automatic void schedule_step(logic op, logic [7:0] id, logic [15:0] burst,
                                          logic [7:0] prio);
        tdjs_pkg::t_res r;
        int k;
        r = '0;
        if (op == tdjs_pkg::OpAdmit) begin
            if (burst == 16'd0 || job_count >= tdjs_pkg::QueueDepth) begin
                r.status = (burst == 16'd0) ? tdjs_pkg::StZeroBurst : tdjs_pkg::StFull;
                r.done_id = id;
                expect_result(r);
            end else begin
                job_id_tbl[job_count] = id;
                job_left_tbl[job_count] = burst;
                job_burst_tbl[job_count] = burst;
                job_arrival_tbl[job_count] = sched_time;
                job_prio_tbl[job_count] = prio;
                job_count++;
            end
            return;
        end
        if (job_count > 0) begin
            k = choose_job();
            job_left_tbl[k] = job_left_tbl[k] - 16'd1;
            if (job_left_tbl[k] == 16'd0) begin
                r.status = tdjs_pkg::StDone;
                r.done_id = job_id_tbl[k];
                r.completion_time = sched_time + 32'd1;
                r.turnaround = r.completion_time - job_arrival_tbl[k];
                r.waiting = r.turnaround - {16'd0, job_burst_tbl[k]};
                expect_result(r);
                for (int i = k; i + 1 < job_count; i++) begin
                    job_id_tbl[i] = job_id_tbl[i + 1];
                    job_left_tbl[i] = job_left_tbl[i + 1];
                    job_burst_tbl[i] = job_burst_tbl[i + 1];
                    job_arrival_tbl[i] = job_arrival_tbl[i + 1];
                    job_prio_tbl[i] = job_prio_tbl[i + 1];
                end
                job_count--;
            end
        end
        sched_time = sched_time + 32'd1;
    endfunction

    // one transaction on the input channel, with an occasional idle burst first
    task automatic send_job(logic op, logic [7:0] id, logic [15:0] burst, logic [7:0] prio);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_job_id <= id;
        i_burst <= burst;
        i_job_priority <= prio;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        schedule_step(op, id, burst, prio);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sched_mode = m;
    endtask

    task automatic random_jobs(int n);
        logic op;
        logic [15:0] burst;
        int roll;
        for (int j = 0; j < n; j++) begin
            roll = $urandom_range(0, 99);
            if (job_count == 0)
                op = (roll < 75) ? tdjs_pkg::OpAdmit : tdjs_pkg::OpTick;
            else if (job_count >= tdjs_pkg::QueueDepth - 2)
                op = (roll < 20) ? tdjs_pkg::OpAdmit : tdjs_pkg::OpTick;
            else
                op = (roll < 35) ? tdjs_pkg::OpAdmit : tdjs_pkg::OpTick;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                burst = 16'd0;
            else if (roll < 10)
                burst = 16'($urandom_range(1, 40));
            else
                burst = 16'($urandom_range(1, 6));
            send_job(op, 8'($urandom), burst, 8'($urandom));
        end
    endtask

    task automatic test_rejects_and_full_table();
        send_job(tdjs_pkg::OpTick, 8'd0, 16'd0, 8'd0);       // tick with nothing stored
        send_job(tdjs_pkg::OpAdmit, 8'hAA, 16'd0, 8'd0);     // zero burst
        for (int i = 0; i < tdjs_pkg::QueueDepth; i++)
            send_job(tdjs_pkg::OpAdmit, 8'(i), 16'd1, 8'(tdjs_pkg::QueueDepth - 1 - i));
        send_job(tdjs_pkg::OpAdmit, 8'hFF, 16'd2, 8'hFF);    // table full
        send_job(tdjs_pkg::OpAdmit, 8'h55, 16'd0, 8'h00);    // zero burst wins over full
        for (int i = 0; i < tdjs_pkg::QueueDepth + 1; i++)
            send_job(tdjs_pkg::OpTick, 8'd0, 16'd0, 8'd0);
    endtask

    task automatic test_policy(logic [1:0] m, int n);
        set_mode(m);
        random_jobs(n);
    endtask

    task automatic test_long_bursts();
        set_mode(tdjs_pkg::ModeSrtf);
        calm = 1'b1;
        // never finishes; srtf keeps serving the short jobs around it
        send_job(tdjs_pkg::OpAdmit, 8'hFF, 16'hFFFF, 8'hFF);
        send_job(tdjs_pkg::OpAdmit, 8'h00, 16'h8001, 8'h00);
        random_jobs(200);
    endtask

    // output idling in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && !calm) begin
            if (ready_gap > 0) begin
                i_ready <= 1'b0;
                ready_gap = ready_gap - 1;
            end else if ($urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                ready_gap = $urandom_range(0, 4);
            end else begin
                i_ready <= 1'b1;
            end
        end else begin
            i_ready <= i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        tdjs_pkg::t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, done_id %0d", o_done_id);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    error_count++;
                end
                if (o_done_id !== want.done_id) begin
                    $error("done_id expected %0d actual %0d", want.done_id, o_done_id);
                    error_count++;
                end
                if (o_completion_time !== want.completion_time) begin
                    $error("completion_time expected %0d actual %0d",
                           want.completion_time, o_completion_time);
                    error_count++;
                end
                if (o_turnaround !== want.turnaround) begin
                    $error("turnaround expected %0d actual %0d", want.turnaround, o_turnaround);
                    error_count++;
                end
                if (o_waiting !== want.waiting) begin
                    $error("waiting expected %0d actual %0d", want.waiting, o_waiting);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        sched_mode = tdjs_pkg::ModeFcfs;
        sched_time = '0;
        job_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rejects_and_full_table();
        test_policy(tdjs_pkg::ModeFcfs, 350);
        test_policy(tdjs_pkg::ModeSrtf, 350);
        test_policy(tdjs_pkg::ModePrio, 350);
        test_policy(ModeSpare, 250);
        test_long_bursts();
        drain();
        if (error_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/tdjs_pkg.sv
rtl/tdjs_front.sv
rtl/tdjs_back.sv
rtl/tick_driven_job_scheduler.sv
tb/tick_driven_job_scheduler_tb.sv
